### design/rayl_pkg.sv
// ----------------------------------------------------------------------------
// rayl_pkg: shared types and constants of the rayleigh function unit
// op and status codes, fixed-point constants and the item record that
// travels down the pipeline next to the arithmetic units
// ----------------------------------------------------------------------------
package rayl_pkg;

  localparam logic [1:0] OP_PDF   = 2'd0;
  localparam logic [1:0] OP_CDF   = 2'd1;
  localparam logic [1:0] OP_QUANT = 2'd2;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_INVALID = 2'd1;
  localparam logic [1:0] ST_INF     = 2'd2;
  localparam logic [1:0] ST_SAT     = 2'd3;

  localparam logic [24:0] ONE_Q24   = 25'd16777216;
  localparam logic [27:0] LN2_Q28   = 28'd186065280;
  localparam logic [29:0] LN2_Q30   = 30'd744261118;
  localparam logic [39:0] VALUE_MAX = 40'hFF_FFFF_FFFF;
  localparam logic [23:0] SCALE_ONE = 24'd65536;

  // per-item record carried as a tag through the units
  typedef struct packed {
    logic [1:0]  op;
    logic [31:0] arg;
    logic [26:0] ratio;  // x/sigma, Q24
    logic        big;    // x/sigma >= 8.0
    logic [24:0] expv;   // exp(-x^2/(2 sigma^2)), Q24
    logic [43:0] ph;     // density partial product, integer part of A
    logic [24:0] pl;     // density partial product, fraction of A
  } rayl_item_t;

  localparam int ITEM_W = $bits(rayl_item_t);

endpackage

### design/rayl_if.sv
// ----------------------------------------------------------------------------
// rayl_if: valid/ready channels of the rayleigh function unit
// rayl_in_if carries op and argument, rayl_out_if carries value and status
// ----------------------------------------------------------------------------
interface rayl_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [31:0] arg;
  modport source (output valid, output op, output arg, input ready);
  modport sink (input valid, input op, input arg, output ready);
endinterface

interface rayl_out_if;
  logic        valid;
  logic        ready;
  logic [39:0] value;
  logic [1:0]  status;
  modport source (output valid, output value, output status, input ready);
  modport sink (input valid, input value, input status, output ready);
endinterface

### design/rayl_div.sv
// ----------------------------------------------------------------------------
// rayl_div: pipelined restoring divider
// one quotient bit per stage; the dividend bits above the quotient must be
// below the divisor; a tag travels with each beat
// ----------------------------------------------------------------------------
module rayl_div #(
  parameter int NW = 47,
  parameter int DW = 24,
  parameter int QW = 47,
  parameter int TW = 8
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          ce,
  input  logic          vld_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  input  logic [TW-1:0] tag_i,
  output logic          vld_o,
  output logic [QW-1:0] quo_o,
  output logic [TW-1:0] tag_o
);

  logic [QW-1:0] vld_r;
  logic [DW-1:0] rem_r [QW];
  logic [QW-1:0] low_r [QW];
  logic [QW-1:0] quo_r [QW];
  logic [DW-1:0] den_r [QW];
  logic [TW-1:0] tag_r [QW];

  logic [QW-1:0] vld_in;
  logic [DW-1:0] rem_in [QW];
  logic [QW-1:0] low_in [QW];
  logic [QW-1:0] quo_in [QW];
  logic [DW-1:0] den_in [QW];
  logic [TW-1:0] tag_in [QW];

  for (genvar i = 0; i < QW; i++) begin : g_stg
    logic [DW:0] x;
    logic [DW:0] diff;
    logic        ge;

    if (i == 0) begin : g_first
      assign vld_in[i] = vld_i;
      assign rem_in[i] = DW'(num_i >> QW);
      assign low_in[i] = num_i[QW-1:0];
      assign quo_in[i] = '0;
      assign den_in[i] = den_i;
      assign tag_in[i] = tag_i;
    end else begin : g_next
      assign vld_in[i] = vld_r[i-1];
      assign rem_in[i] = rem_r[i-1];
      assign low_in[i] = low_r[i-1];
      assign quo_in[i] = quo_r[i-1];
      assign den_in[i] = den_r[i-1];
      assign tag_in[i] = tag_r[i-1];
    end

    assign x    = {rem_in[i], low_in[i][QW-1]};
    assign diff = x - {1'b0, den_in[i]};
    assign ge   = x >= {1'b0, den_in[i]};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i] <= 1'b0;
      end else if (ce) begin
        vld_r[i] <= vld_in[i];
      end
    end

    always_ff @(posedge clk) begin
      if (ce) begin
        rem_r[i] <= ge ? diff[DW-1:0] : x[DW-1:0];
        low_r[i] <= low_in[i] << 1;
        quo_r[i] <= {quo_in[i][QW-2:0], ge};
        den_r[i] <= den_in[i];
        tag_r[i] <= tag_in[i];
      end
    end
  end

  assign vld_o = vld_r[QW-1];
  assign quo_o = quo_r[QW-1];
  assign tag_o = tag_r[QW-1];

endmodule

### design/rayl_exp.sv
// ----------------------------------------------------------------------------
// rayl_exp: pipelined exp(-t), t in Q24, result in Q24
// range reduction by ln2, 12-term taylor series, reciprocal by divider
// ----------------------------------------------------------------------------
module rayl_exp import rayl_pkg::*; #(
  parameter int TW = 8
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          ce,
  input  logic          vld_i,
  input  logic [28:0]   t_i,
  input  logic [TW-1:0] tag_i,
  output logic          vld_o,
  output logic [24:0]   e_o,
  output logic [TW-1:0] tag_o
);

  localparam int NT = 12;

  // ---- k = floor(t/ln2), 6 compare-subtract stages
  logic [5:0]    kv_r;
  logic [32:0]   krem_r [6];
  logic [5:0]    kq_r [6];
  logic [TW-1:0] ktag_r [6];

  for (genvar j = 0; j < 6; j++) begin : g_k
    localparam logic [33:0] KC = 34'(LN2_Q28) << (5 - j);
    logic          vin;
    logic [32:0]   rin;
    logic [5:0]    qin;
    logic [TW-1:0] tin;
    logic          ge;

    if (j == 0) begin : g_first
      assign vin = vld_i;
      assign rin = {t_i, 4'b0};
      assign qin = '0;
      assign tin = tag_i;
    end else begin : g_next
      assign vin = kv_r[j-1];
      assign rin = krem_r[j-1];
      assign qin = kq_r[j-1];
      assign tin = ktag_r[j-1];
    end

    assign ge = {1'b0, rin} >= KC;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        kv_r[j] <= 1'b0;
      end else if (ce) begin
        kv_r[j] <= vin;
      end
    end

    always_ff @(posedge clk) begin
      if (ce) begin
        krem_r[j] <= ge ? 33'({1'b0, rin} - KC) : rin;
        kq_r[j]   <= {qin[4:0], ge};
        ktag_r[j] <= tin;
      end
    end
  end

  // ---- taylor series, three stages per term
  logic [NT-1:0] av_r, bv_r, cv_r;
  logic [56:0]   a_prod_r [NT];
  logic [29:0]   a_sum_r [NT], b_sum_r [NT], c_sum_r [NT];
  logic [27:0]   a_r_r [NT], b_r_r [NT], c_r_r [NT];
  logic [5:0]    a_k_r [NT], b_k_r [NT], c_k_r [NT];
  logic [TW-1:0] a_tag_r [NT], b_tag_r [NT], c_tag_r [NT];
  logic [28:0]   b_v_r [NT];
  logic [61:0]   b_pm_r [NT];
  logic [28:0]   c_term_r [NT];

  for (genvar i = 0; i < NT; i++) begin : g_term
    localparam int          N = i + 1;
    localparam logic [32:0] M = 33'((64'd1 << 32) / N);
    logic          vin;
    logic [28:0]   term_in;
    logic [29:0]   sum_in;
    logic [27:0]   r_in;
    logic [5:0]    k_in;
    logic [TW-1:0] tag_in;
    logic [28:0]   v;
    logic [28:0]   q0;
    logic [28:0]   rr;
    logic [28:0]   qq;

    if (i == 0) begin : g_first
      assign vin     = kv_r[5];
      assign term_in = 29'd1 << 28;
      assign sum_in  = 30'd1 << 28;
      assign r_in    = krem_r[5][27:0];
      assign k_in    = kq_r[5];
      assign tag_in  = ktag_r[5];
    end else begin : g_next
      assign vin     = cv_r[i-1];
      assign term_in = c_term_r[i-1];
      assign sum_in  = c_sum_r[i-1];
      assign r_in    = c_r_r[i-1];
      assign k_in    = c_k_r[i-1];
      assign tag_in  = c_tag_r[i-1];
    end

    assign v  = a_prod_r[i][56:28];
    assign q0 = b_pm_r[i][60:32];
    assign rr = b_v_r[i] - 29'(33'(q0) * 33'(N));
    assign qq = (rr >= 29'(N)) ? q0 + 29'd1 : q0;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        av_r[i] <= 1'b0;
        bv_r[i] <= 1'b0;
        cv_r[i] <= 1'b0;
      end else if (ce) begin
        av_r[i] <= vin;
        bv_r[i] <= av_r[i];
        cv_r[i] <= bv_r[i];
      end
    end

    always_ff @(posedge clk) begin
      if (ce) begin
        a_prod_r[i] <= 57'(term_in) * 57'(r_in);
        a_sum_r[i]  <= sum_in;
        a_r_r[i]    <= r_in;
        a_k_r[i]    <= k_in;
        a_tag_r[i]  <= tag_in;
        b_v_r[i]    <= v;
        b_pm_r[i]   <= 62'(v) * 62'(M);
        b_sum_r[i]  <= a_sum_r[i];
        b_r_r[i]    <= a_r_r[i];
        b_k_r[i]    <= a_k_r[i];
        b_tag_r[i]  <= a_tag_r[i];
        c_term_r[i] <= qq;
        c_sum_r[i]  <= b_sum_r[i] + 30'(qq);
        c_r_r[i]    <= b_r_r[i];
        c_k_r[i]    <= b_k_r[i];
        c_tag_r[i]  <= b_tag_r[i];
      end
    end
  end

  // ---- reciprocal 2^56/sum
  logic          dv;
  logic [28:0]   dinv;
  logic [TW+5:0] dtag;
  logic [5:0]    dk;
  logic          vo_r;
  logic [24:0]   e_r;
  logic [TW-1:0] tag_r;
  logic [24:0]   e_nxt;

  rayl_div #(.NW(57), .DW(30), .QW(29), .TW(TW + 6)) u_inv (
    .clk   (clk),
    .rst_n (rst_n),
    .ce    (ce),
    .vld_i (cv_r[NT-1]),
    .num_i (57'd1 << 56),
    .den_i (c_sum_r[NT-1]),
    .tag_i ({c_tag_r[NT-1], c_k_r[NT-1]}),
    .vld_o (dv),
    .quo_o (dinv),
    .tag_o (dtag)
  );

  assign dk    = dtag[5:0];
  assign e_nxt = (dk >= 6'd40) ? 25'd0 : 25'(dinv >> (dk + 6'd4));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vo_r <= 1'b0;
    end else if (ce) begin
      vo_r <= dv;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      e_r   <= e_nxt;
      tag_r <= dtag[TW+5:6];
    end
  end

  assign vld_o = vo_r;
  assign e_o   = e_r;
  assign tag_o = tag_r;

endmodule

### design/rayl_ln.sv
// ----------------------------------------------------------------------------
// rayl_ln: pipelined w = -2 ln(q), q in Q24, w in Q30
// normalize to [0.5,1), atanh argument by divider, 12-term series
// ----------------------------------------------------------------------------
module rayl_ln import rayl_pkg::*; #(
  parameter int TW = 8
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          ce,
  input  logic          vld_i,
  input  logic [23:0]   q_i,
  input  logic [TW-1:0] tag_i,
  output logic          vld_o,
  output logic [36:0]   w_o,
  output logic [TW-1:0] tag_o
);

  localparam int NT = 12;

  // ---- normalize
  logic          nv_r;
  logic [4:0]    ne_r;
  logic [23:0]   nm_r;
  logic [TW-1:0] ntag_r;
  logic [4:0]    lz_nxt;

  always_comb begin
    lz_nxt = 5'd0;
    for (int b = 0; b < 24; b++) begin
      if (q_i[b]) lz_nxt = 5'(23 - b);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nv_r <= 1'b0;
    end else if (ce) begin
      nv_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      ne_r   <= lz_nxt;
      nm_r   <= q_i << lz_nxt;
      ntag_r <= tag_i;
    end
  end

  // ---- u = (1-m)/(1+m)
  logic          dv;
  logic [29:0]   du;
  logic [TW+4:0] dtag;

  rayl_div #(.NW(54), .DW(25), .QW(30), .TW(TW + 5)) u_atn (
    .clk   (clk),
    .rst_n (rst_n),
    .ce    (ce),
    .vld_i (nv_r),
    .num_i ({24'(ONE_Q24 - 25'(nm_r)), 30'b0}),
    .den_i (ONE_Q24 + 25'(nm_r)),
    .tag_i ({ntag_r, ne_r}),
    .vld_o (dv),
    .quo_o (du),
    .tag_o (dtag)
  );

  logic          uv_r;
  logic [29:0]   u_r;
  logic [29:0]   u2_r;
  logic [4:0]    ue_r;
  logic [TW-1:0] utag_r;
  logic [59:0]   usq;

  assign usq = 60'(du) * 60'(du);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      uv_r <= 1'b0;
    end else if (ce) begin
      uv_r <= dv;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      u_r    <= du;
      u2_r   <= usq[59:30];
      ue_r   <= dtag[4:0];
      utag_r <= dtag[TW+4:5];
    end
  end

  // ---- atanh series, two stages per term
  logic [NT-1:0] av_r, bv_r;
  logic [62:0]   a_pm_r [NT];
  logic [29:0]   a_pw_r [NT], a_pwn_r [NT], a_u2_r [NT];
  logic [30:0]   a_sum_r [NT];
  logic [4:0]    a_e_r [NT];
  logic [TW-1:0] a_tag_r [NT];
  logic [29:0]   b_pw_r [NT], b_u2_r [NT];
  logic [30:0]   b_sum_r [NT];
  logic [4:0]    b_e_r [NT];
  logic [TW-1:0] b_tag_r [NT];

  for (genvar j = 0; j < NT; j++) begin : g_term
    localparam int          N = 2 * j + 1;
    localparam logic [32:0] M = 33'((64'd1 << 32) / N);
    logic          vin;
    logic [29:0]   pw_in;
    logic [29:0]   u2_in;
    logic [30:0]   sum_in;
    logic [4:0]    e_in;
    logic [TW-1:0] tag_in;
    logic [59:0]   pp;
    logic [29:0]   q0;
    logic [29:0]   rr;
    logic [29:0]   qq;

    if (j == 0) begin : g_first
      assign vin    = uv_r;
      assign pw_in  = u_r;
      assign u2_in  = u2_r;
      assign sum_in = '0;
      assign e_in   = ue_r;
      assign tag_in = utag_r;
    end else begin : g_next
      assign vin    = bv_r[j-1];
      assign pw_in  = b_pw_r[j-1];
      assign u2_in  = b_u2_r[j-1];
      assign sum_in = b_sum_r[j-1];
      assign e_in   = b_e_r[j-1];
      assign tag_in = b_tag_r[j-1];
    end

    assign pp = 60'(pw_in) * 60'(u2_in);
    assign q0 = a_pm_r[j][61:32];
    assign rr = a_pw_r[j] - 30'(34'(q0) * 34'(N));
    assign qq = (rr >= 30'(N)) ? q0 + 30'd1 : q0;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        av_r[j] <= 1'b0;
        bv_r[j] <= 1'b0;
      end else if (ce) begin
        av_r[j] <= vin;
        bv_r[j] <= av_r[j];
      end
    end

    always_ff @(posedge clk) begin
      if (ce) begin
        a_pm_r[j]  <= 63'(pw_in) * 63'(M);
        a_pw_r[j]  <= pw_in;
        a_pwn_r[j] <= pp[59:30];
        a_u2_r[j]  <= u2_in;
        a_sum_r[j] <= sum_in;
        a_e_r[j]   <= e_in;
        a_tag_r[j] <= tag_in;
        b_pw_r[j]  <= a_pwn_r[j];
        b_u2_r[j]  <= a_u2_r[j];
        b_sum_r[j] <= a_sum_r[j] + 31'(qq);
        b_e_r[j]   <= a_e_r[j];
        b_tag_r[j] <= a_tag_r[j];
      end
    end
  end

  // ---- w = 2 (e ln2 + 2 sum)
  logic          vo_r;
  logic [36:0]   w_r;
  logic [TW-1:0] tag_r;
  logic [34:0]   eln;
  logic [35:0]   l_nxt;

  assign eln   = 35'(b_e_r[NT-1]) * 35'(LN2_Q30);
  assign l_nxt = 36'(eln) + 36'({b_sum_r[NT-1], 1'b0});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vo_r <= 1'b0;
    end else if (ce) begin
      vo_r <= bv_r[NT-1];
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      w_r   <= {l_nxt, 1'b0};
      tag_r <= b_tag_r[NT-1];
    end
  end

  assign vld_o = vo_r;
  assign w_o   = w_r;
  assign tag_o = tag_r;

endmodule

### design/rayl_sqrt.sv
// ----------------------------------------------------------------------------
// rayl_sqrt: pipelined integer square root of a 54-bit value
// one root bit per stage, floor result
// ----------------------------------------------------------------------------
module rayl_sqrt #(
  parameter int TW = 8
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          ce,
  input  logic          vld_i,
  input  logic [53:0]   v_i,
  input  logic [TW-1:0] tag_i,
  output logic          vld_o,
  output logic [26:0]   root_o,
  output logic [TW-1:0] tag_o
);

  localparam int NS = 27;

  logic [NS-1:0] vld_r;
  logic [28:0]   rem_r [NS];
  logic [26:0]   root_r [NS];
  logic [53:0]   low_r [NS];
  logic [TW-1:0] tag_r [NS];

  for (genvar i = 0; i < NS; i++) begin : g_stg
    logic          vin;
    logic [28:0]   rem_in;
    logic [26:0]   root_in;
    logic [53:0]   low_in;
    logic [TW-1:0] tag_in;
    logic [30:0]   x;
    logic [30:0]   trial;
    logic          ge;

    if (i == 0) begin : g_first
      assign vin     = vld_i;
      assign rem_in  = '0;
      assign root_in = '0;
      assign low_in  = v_i;
      assign tag_in  = tag_i;
    end else begin : g_next
      assign vin     = vld_r[i-1];
      assign rem_in  = rem_r[i-1];
      assign root_in = root_r[i-1];
      assign low_in  = low_r[i-1];
      assign tag_in  = tag_r[i-1];
    end

    assign x     = {rem_in, low_in[53:52]};
    assign trial = {2'b00, root_in, 2'b01};
    assign ge    = x >= trial;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i] <= 1'b0;
      end else if (ce) begin
        vld_r[i] <= vin;
      end
    end

    always_ff @(posedge clk) begin
      if (ce) begin
        rem_r[i]  <= ge ? 29'(x - trial) : 29'(x);
        root_r[i] <= {root_in[25:0], ge};
        low_r[i]  <= low_in << 2;
        tag_r[i]  <= tag_in;
      end
    end
  end

  assign vld_o  = vld_r[NS-1];
  assign root_o = root_r[NS-1];
  assign tag_o  = tag_r[NS-1];

endmodule

### design/rayleigh_pdf_cdf_quantile.sv
// ----------------------------------------------------------------------------
// rayleigh_pdf_cdf_quantile: rayleigh density, distribution and quantile
// fully pipelined fixed-point unit, scale sigma held in a register
// ----------------------------------------------------------------------------
//  port    | dir | handshake   | beat contents
//  --------+-----+-------------+------------------------------------------
//  in_ch   | in  | valid/ready | op (2b), arg (signed Q8.24)
//  out_ch  | out | valid/ready | value (unsigned Q16.24), status (2b)
//  cfg_*   | in  | cfg_we      | cfg_wdata = sigma, unsigned Q8.16
//
// one beat accepted per cycle while the output is not stalled; every beat
// passes in order through the x/sigma divider, exp unit, density divider,
// log unit and square root plus four top stages
// reset (rst_n low, synchronous) empties the pipeline and sets sigma to 1.0
// a stall at the output freezes the whole pipeline; in_ch.ready drops in
// the same cycle, so nothing is lost or repeated
// ----------------------------------------------------------------------------
module rayleigh_pdf_cdf_quantile import rayl_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [23:0]      cfg_wdata,
  rayl_in_if.sink          in_ch,
  rayl_out_if.source       out_ch
);

  // sigma register, zero reads as 1.0
  logic [23:0] scale_r;
  logic [23:0] sig;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r <= SCALE_ONE;
    end else if (cfg_we) begin
      scale_r <= cfg_wdata;
    end
  end

  assign sig = (scale_r == 24'd0) ? SCALE_ONE : scale_r;

  // global advance: the whole pipe moves unless the output beat is held
  logic ce;
  logic out_vld_r;

  assign ce          = !out_vld_r || out_ch.ready;
  assign in_ch.ready = ce;

  // ---- R = x/sigma in Q24
  rayl_item_t             it_in;
  logic                   d1_vld;
  logic [46:0]            d1_quo;
  logic [ITEM_W-1:0]      d1_tag;

  always_comb begin
    it_in     = '0;
    it_in.op  = in_ch.op;
    it_in.arg = in_ch.arg;
  end

  rayl_div #(.NW(47), .DW(24), .QW(47), .TW(ITEM_W)) u_ratio (
    .clk   (clk),
    .rst_n (rst_n),
    .ce    (ce),
    .vld_i (in_ch.valid),
    .num_i ({in_ch.arg[30:0], 16'b0}),
    .den_i (sig),
    .tag_i (it_in),
    .vld_o (d1_vld),
    .quo_o (d1_quo),
    .tag_o (d1_tag)
  );

  // ---- t = R^2/2
  logic        tv_r;
  rayl_item_t  tit_r;
  logic [28:0] t_r;
  rayl_item_t  tit_nxt;
  logic [53:0] rsq;

  always_comb begin
    tit_nxt       = rayl_item_t'(d1_tag);
    tit_nxt.ratio = d1_quo[26:0];
    tit_nxt.big   = |d1_quo[46:27];
  end

  assign rsq = 54'(d1_quo[26:0]) * 54'(d1_quo[26:0]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tv_r <= 1'b0;
    end else if (ce) begin
      tv_r <= d1_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      tit_r <= tit_nxt;
      t_r   <= rsq[53:25];
    end
  end

  // ---- E = exp(-t), zero once x/sigma reaches 8
  logic              ex_vld;
  logic [24:0]       ex_val;
  logic [ITEM_W-1:0] ex_tag;
  rayl_item_t        eit;

  rayl_exp #(.TW(ITEM_W)) u_exp (
    .clk   (clk),
    .rst_n (rst_n),
    .ce    (ce),
    .vld_i (tv_r),
    .t_i   (t_r),
    .tag_i (tit_r),
    .vld_o (ex_vld),
    .e_o   (ex_val),
    .tag_o (ex_tag)
  );

  always_comb begin
    eit      = rayl_item_t'(ex_tag);
    eit.expv = eit.big ? 25'd0 : ex_val;
  end

  // ---- A = R/sigma for the density
  logic              d2_vld;
  logic [42:0]       d2_quo;
  logic [ITEM_W-1:0] d2_tag;

  rayl_div #(.NW(43), .DW(24), .QW(43), .TW(ITEM_W)) u_dens (
    .clk   (clk),
    .rst_n (rst_n),
    .ce    (ce),
    .vld_i (ex_vld),
    .num_i ({eit.ratio, 16'b0}),
    .den_i (sig),
    .tag_i (eit),
    .vld_o (d2_vld),
    .quo_o (d2_quo),
    .tag_o (d2_tag)
  );

  // ---- density partial products A*E
  logic       pv_r;
  rayl_item_t pit_r;
  rayl_item_t pit_nxt;
  logic [48:0] plo;

  always_comb begin
    pit_nxt    = rayl_item_t'(d2_tag);
    pit_nxt.ph = 44'(d2_quo[42:24]) * 44'(pit_nxt.expv);
    plo        = 49'(d2_quo[23:0]) * 49'(pit_nxt.expv);
    pit_nxt.pl = plo[48:24];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r <= 1'b0;
    end else if (ce) begin
      pv_r <= d2_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      pit_r <= pit_nxt;
    end
  end

  // ---- quantile: w = -2 ln(1-p), root = sqrt(w)
  logic              ln_vld;
  logic [36:0]       ln_w;
  logic [ITEM_W-1:0] ln_tag;
  logic              sq_vld;
  logic [26:0]       sq_root;
  logic [ITEM_W-1:0] sq_tag;

  rayl_ln #(.TW(ITEM_W)) u_ln (
    .clk   (clk),
    .rst_n (rst_n),
    .ce    (ce),
    .vld_i (pv_r),
    .q_i   (24'(ONE_Q24 - pit_r.arg[24:0])),
    .tag_i (pit_r),
    .vld_o (ln_vld),
    .w_o   (ln_w),
    .tag_o (ln_tag)
  );

  rayl_sqrt #(.TW(ITEM_W)) u_sqrt (
    .clk    (clk),
    .rst_n  (rst_n),
    .ce     (ce),
    .vld_i  (ln_vld),
    .v_i    ({ln_w[35:0], 18'b0}),
    .tag_i  (ln_tag),
    .vld_o  (sq_vld),
    .root_o (sq_root),
    .tag_o  (sq_tag)
  );

  // ---- sigma*root and density sum
  logic        fv_r;
  rayl_item_t  fit_r;
  logic [34:0] fq_r;
  logic [44:0] fd_r;
  logic [50:0] qprod;
  rayl_item_t  sit;

  assign sit   = rayl_item_t'(sq_tag);
  assign qprod = 51'(sig) * 51'(sq_root);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fv_r <= 1'b0;
    end else if (ce) begin
      fv_r <= sq_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      fit_r <= sit;
      fq_r  <= qprod[50:16];
      fd_r  <= 45'(sit.ph) + 45'(sit.pl);
    end
  end

  // ---- result select, special cases and saturation
  logic [44:0] val;
  logic [39:0] value_nxt;
  logic [1:0]  status_nxt;
  logic [39:0] value_r;
  logic [1:0]  status_r;

  always_comb begin
    val        = '0;
    status_nxt = ST_OK;
    unique case (fit_r.op) inside
      OP_PDF, OP_CDF: begin
        if (!fit_r.arg[31] && fit_r.arg != 32'd0) begin
          if (fit_r.op == OP_PDF) begin
            val = fd_r;
          end else begin
            val = 45'(ONE_Q24 - fit_r.expv);
          end
        end
      end
      OP_QUANT: begin
        if (fit_r.arg[31] || fit_r.arg > 32'(ONE_Q24)) begin
          status_nxt = ST_INVALID;
        end else if (fit_r.arg == 32'(ONE_Q24)) begin
          val        = 45'(VALUE_MAX);
          status_nxt = ST_INF;
        end else if (fit_r.arg != 32'd0) begin
          val = 45'(fq_r);
        end
      end
      default: begin
        status_nxt = ST_INVALID;
      end
    endcase
    if (val > 45'(VALUE_MAX)) begin
      value_nxt  = VALUE_MAX;
      status_nxt = ST_SAT;
    end else begin
      value_nxt = val[39:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (ce) begin
      out_vld_r <= fv_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      value_r  <= value_nxt;
      status_r <= status_nxt;
    end
  end

  assign out_ch.valid  = out_vld_r;
  assign out_ch.value  = value_r;
  assign out_ch.status = status_r;

endmodule

### design/rayl_checker.sv
// ----------------------------------------------------------------------------
// rayl_checker: port-level checks of the rayleigh function unit
// bound to the top level
// ----------------------------------------------------------------------------
module rayl_checker import rayl_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [39:0] out_value,
  input logic [1:0]  out_status
);

  // held output beat keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_value) && $stable(out_status))
    else $error("output beat changed while stalled");

  // a held output freezes the pipe, so no new beat may enter
  a_in_block: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("input accepted during output stall");

  a_inf_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_INF |-> out_value == VALUE_MAX)
    else $error("infinite result without maximum value");

  a_sat_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_SAT |-> out_value == VALUE_MAX)
    else $error("saturated result without maximum value");

  a_inv_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_INVALID |-> out_value == 40'd0)
    else $error("invalid result with nonzero value");

endmodule

bind rayleigh_pdf_cdf_quantile rayl_checker u_rayl_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_value  (out_ch.value),
  .out_status (out_ch.status)
);
